>>> design/obr_pkg.sv
// ----------------------------------------------------------------------------
// obr_pkg
// Shared widths, period table, command codes and beat types for the bar
// resampler.
// ----------------------------------------------------------------------------
package obr_pkg;

	localparam int TIME_W   = 53;
	localparam int PRICE_W  = 32;
	localparam int VOL_IN_W = 32;
	localparam int VOL_W    = 48;
	localparam int SEL_W    = 3;
	localparam int PER_W    = 29;
	localparam int RCP_W    = 32;
	localparam int QDEPTH   = 2;

	localparam int DEF_MAX_GAP_BARS = 63;
	localparam int DEF_PRICE_BITS   = 32;

	localparam longint unsigned TIME_SPAN = 64'd1 << TIME_W;

	localparam logic [SEL_W-1:0] SEL_5S   = 3'd0;
	localparam logic [SEL_W-1:0] SEL_15S  = 3'd1;
	localparam logic [SEL_W-1:0] SEL_30S  = 3'd2;
	localparam logic [SEL_W-1:0] SEL_60S  = 3'd3;
	localparam logic [SEL_W-1:0] SEL_180S = 3'd4;

	typedef enum logic [1:0] {
		CMD_OPEN,
		CMD_MERGE,
		CMD_CLOSE
	} cmd_kind_t;

	typedef struct packed {
		logic [TIME_W-1:0]   t_us;
		logic [PRICE_W-1:0]  px_open;
		logic [PRICE_W-1:0]  px_high;
		logic [PRICE_W-1:0]  px_low;
		logic [PRICE_W-1:0]  px_close;
		logic [VOL_IN_W-1:0] vol;
	} row_t;

	typedef struct packed {
		cmd_kind_t         kind;
		row_t              row;
		logic [TIME_W-1:0] new_edge;
		logic [PER_W-1:0]  per;
	} cmd_t;

	// bar period in microseconds, unknown selects act as 300 s
	function automatic logic [PER_W-1:0] period_us(input logic [SEL_W-1:0] sel);
		logic [PER_W-1:0] p;
		unique case (sel)
			SEL_5S:   p = PER_W'(5_000_000);
			SEL_15S:  p = PER_W'(15_000_000);
			SEL_30S:  p = PER_W'(30_000_000);
			SEL_60S:  p = PER_W'(60_000_000);
			SEL_180S: p = PER_W'(180_000_000);
			default:  p = PER_W'(300_000_000);
		endcase
		return p;
	endfunction

	// floor(2^53 / period), for the quotient estimate from the top time bits
	function automatic logic [RCP_W-1:0] period_rcp(input logic [SEL_W-1:0] sel);
		logic [RCP_W-1:0] r;
		unique case (sel)
			SEL_5S:   r = RCP_W'(TIME_SPAN / 64'd5_000_000);
			SEL_15S:  r = RCP_W'(TIME_SPAN / 64'd15_000_000);
			SEL_30S:  r = RCP_W'(TIME_SPAN / 64'd30_000_000);
			SEL_60S:  r = RCP_W'(TIME_SPAN / 64'd60_000_000);
			SEL_180S: r = RCP_W'(TIME_SPAN / 64'd180_000_000);
			default:  r = RCP_W'(TIME_SPAN / 64'd300_000_000);
		endcase
		return r;
	endfunction

endpackage

>>> design/obr_front.sv
// ----------------------------------------------------------------------------
// obr_front
// Accepts rows, classifies them against the current bar edge and works out
// the edge of a new bar with a reciprocal multiply and a short remainder fix.
// ----------------------------------------------------------------------------
module obr_front #(
	parameter int PRICE_BITS = obr_pkg::DEF_PRICE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [obr_pkg::SEL_W-1:0]     period_select,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [obr_pkg::TIME_W-1:0]    tick_time_us,
	input  logic [obr_pkg::PRICE_W-1:0]   row_open,
	input  logic [obr_pkg::PRICE_W-1:0]   row_high,
	input  logic [obr_pkg::PRICE_W-1:0]   row_low,
	input  logic [obr_pkg::PRICE_W-1:0]   row_close,
	input  logic [obr_pkg::VOL_IN_W-1:0]  row_volume,
	output logic                          push,
	output obr_pkg::cmd_t                 push_cmd,
	input  logic                          q_full
);
	import obr_pkg::*;

	localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
	localparam int RW = PER_W + 2;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_CLASS = 3'd1;
	localparam logic [2:0] F_MUL   = 3'd2;
	localparam logic [2:0] F_REM   = 3'd3;
	localparam logic [2:0] F_FIX   = 3'd4;
	localparam logic [2:0] F_EDGE  = 3'd5;
	localparam logic [2:0] F_PUSH  = 3'd6;

	logic [2:0]        state_q;
	logic              active_q;
	logic [TIME_W-1:0] edge_q;
	row_t              row_q;
	cmd_kind_t         kind_q;
	logic [RCP_W-1:0]  quo_q;
	logic [RW-1:0]     rem_q;

	logic [PER_W-1:0]   per;
	logic [RCP_W-1:0]   rcp;
	logic [RCP_W-1:0]   t_hi;
	logic [2*RCP_W-1:0] rcp_prod;
	logic [RW-1:0]      qp_lo;
	logic               rem_ge;
	logic               is_merge;
	logic [TIME_W:0]    up_sum;
	logic [TIME_W-1:0]  new_edge;

	assign per  = period_us(period_select);
	assign rcp  = period_rcp(period_select);
	assign t_hi = row_q.t_us[TIME_W-1 -: RCP_W];

	// quotient estimate is at most two below the true quotient
	assign rcp_prod = (2*RCP_W)'(t_hi) * (2*RCP_W)'(rcp);
	assign qp_lo    = quo_q[RW-1:0] * RW'(per);
	assign rem_ge   = rem_q >= RW'(per);

	assign is_merge = active_q && (row_q.t_us <= edge_q);

	// round up to the grid, saturating at the top of the time range
	assign up_sum   = {1'b0, row_q.t_us} + (TIME_W+1)'(per - rem_q[PER_W-1:0]);
	assign new_edge = (rem_q == '0) ? row_q.t_us :
		(up_sum[TIME_W] ? {TIME_W{1'b1}} : up_sum[TIME_W-1:0]);

	assign in_stall = (state_q != F_IDLE);

	assign push = !q_full &&
		(((state_q == F_CLASS) && is_merge) || (state_q == F_PUSH));

	always_comb begin
		push_cmd.kind     = (state_q == F_CLASS) ? CMD_MERGE : kind_q;
		push_cmd.row      = row_q;
		push_cmd.new_edge = edge_q;
		push_cmd.per      = per;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			active_q <= 1'b0;
			edge_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_CLASS;
					end
				end
				F_CLASS: begin
					if (is_merge) begin
						if (!q_full) begin
							state_q <= F_IDLE;
						end
					end else begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_REM;
				end
				F_REM: begin
					state_q <= F_FIX;
				end
				F_FIX: begin
					if (!rem_ge) begin
						state_q <= F_EDGE;
					end
				end
				F_EDGE: begin
					edge_q   <= new_edge;
					active_q <= 1'b1;
					state_q  <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			row_q.t_us     <= tick_time_us;
			row_q.px_open  <= PRICE_W'(row_open[PW-1:0]);
			row_q.px_high  <= PRICE_W'(row_high[PW-1:0]);
			row_q.px_low   <= PRICE_W'(row_low[PW-1:0]);
			row_q.px_close <= PRICE_W'(row_close[PW-1:0]);
			row_q.vol      <= row_volume;
		end
		if (state_q == F_CLASS && !is_merge) begin
			kind_q <= active_q ? CMD_CLOSE : CMD_OPEN;
		end
		if (state_q == F_MUL) begin
			quo_q <= rcp_prod[2*RCP_W-1:RCP_W];
		end
		if (state_q == F_REM) begin
			rem_q <= row_q.t_us[RW-1:0] - qp_lo;
		end
		if (state_q == F_FIX && rem_ge) begin
			rem_q <= rem_q - RW'(per);
		end
	end

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_EDGE) |-> (rem_q < RW'(per)))
		else $error("remainder not below the period at edge update");

endmodule

>>> design/obr_queue.sv
// ----------------------------------------------------------------------------
// obr_queue
// Short command queue between the classifier and the bar builder.
// ----------------------------------------------------------------------------
module obr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  obr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output obr_pkg::cmd_t pop_cmd,
	output logic          empty
);
	import obr_pkg::*;

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign full    = (count_q == QCW'(QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command popped from empty queue");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("pushed command lost");

endmodule

>>> design/obr_back.sv
// ----------------------------------------------------------------------------
// obr_back
// Holds the open bar, merges rows into it and emits the finished bar and the
// filler bars through an output register.
// ----------------------------------------------------------------------------
module obr_back #(
	parameter int MAX_GAP_BARS = obr_pkg::DEF_MAX_GAP_BARS,
	parameter int PRICE_BITS   = obr_pkg::DEF_PRICE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  obr_pkg::cmd_t               q_cmd,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [obr_pkg::TIME_W-1:0]  bar_time_us,
	output logic [obr_pkg::PRICE_W-1:0] bar_open,
	output logic [obr_pkg::PRICE_W-1:0] bar_high,
	output logic [obr_pkg::PRICE_W-1:0] bar_low,
	output logic [obr_pkg::PRICE_W-1:0] bar_close,
	output logic [obr_pkg::VOL_W-1:0]   bar_volume,
	output logic                        is_empty_bar,
	output logic                        gap_truncated,
	output logic                        last_of_run
);
	import obr_pkg::*;

	localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
	localparam int GW = $clog2(MAX_GAP_BARS + 1);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_REAL = 2'd1;
	localparam logic [1:0] B_GAP  = 2'd2;

	logic [1:0]        state_q;
	logic [TIME_W-1:0] edge_q;
	logic [PW-1:0]     acc_open_q;
	logic [PW-1:0]     acc_high_q;
	logic [PW-1:0]     acc_low_q;
	logic [PW-1:0]     acc_close_q;
	logic [VOL_W-1:0]  acc_vol_q;
	logic              out_valid_q;

	cmd_t              cmd_q;
	logic [TIME_W:0]   fe_q;
	logic [GW-1:0]     i_q;

	logic              ofree;
	logic              emit;
	logic              fe_more;
	logic [TIME_W:0]   fe_nxt;
	logic              nxt_more;
	logic              gap_cap;
	logic              last_now;
	logic              finish;
	logic [VOL_W:0]    vol_sum;
	logic [PW-1:0]     in_high;
	logic [PW-1:0]     in_low;

	assign ofree    = !out_valid_q || !out_stall;
	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign emit     = ofree && ((state_q == B_REAL) || (state_q == B_GAP));
	assign fe_more  = fe_q < {1'b0, cmd_q.row.t_us};
	assign fe_nxt   = fe_q + (TIME_W+1)'(cmd_q.per);
	assign nxt_more = fe_nxt < {1'b0, cmd_q.row.t_us};
	assign gap_cap  = (i_q == GW'(MAX_GAP_BARS));
	assign last_now = (state_q == B_REAL) ? !fe_more : (gap_cap || !nxt_more);
	assign finish   = emit && last_now;

	assign in_high = q_cmd.row.px_high[PW-1:0];
	assign in_low  = q_cmd.row.px_low[PW-1:0];
	assign vol_sum = (VOL_W+1)'(acc_vol_q) + (VOL_W+1)'(q_cmd.row.vol);

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			edge_q      <= '0;
			acc_open_q  <= '0;
			acc_high_q  <= '0;
			acc_low_q   <= '0;
			acc_close_q <= '0;
			acc_vol_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ofree) begin
				out_valid_q <= emit;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						unique case (q_cmd.kind)
							CMD_OPEN: begin
								edge_q      <= q_cmd.new_edge;
								acc_open_q  <= q_cmd.row.px_open[PW-1:0];
								acc_high_q  <= in_high;
								acc_low_q   <= in_low;
								acc_close_q <= q_cmd.row.px_close[PW-1:0];
								acc_vol_q   <= VOL_W'(q_cmd.row.vol);
							end
							CMD_MERGE: begin
								if (in_high > acc_high_q) begin
									acc_high_q <= in_high;
								end
								if (in_low < acc_low_q) begin
									acc_low_q <= in_low;
								end
								acc_close_q <= q_cmd.row.px_close[PW-1:0];
								acc_vol_q   <= vol_sum[VOL_W] ? {VOL_W{1'b1}} :
									vol_sum[VOL_W-1:0];
							end
							CMD_CLOSE: begin
								state_q <= B_REAL;
							end
							default: begin
								state_q <= B_IDLE;
							end
						endcase
					end
				end
				B_REAL, B_GAP: begin
					if (finish) begin
						state_q     <= B_IDLE;
						edge_q      <= cmd_q.new_edge;
						acc_open_q  <= cmd_q.row.px_open[PW-1:0];
						acc_high_q  <= cmd_q.row.px_high[PW-1:0];
						acc_low_q   <= cmd_q.row.px_low[PW-1:0];
						acc_close_q <= cmd_q.row.px_close[PW-1:0];
						acc_vol_q   <= VOL_W'(cmd_q.row.vol);
					end else if (emit) begin
						state_q <= B_GAP;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_cmd.kind == CMD_CLOSE) begin
			cmd_q <= q_cmd;
			fe_q  <= {1'b0, edge_q} + (TIME_W+1)'(q_cmd.per);
		end
		if (emit) begin
			last_of_run <= last_now;
			if (state_q == B_REAL) begin
				bar_time_us   <= edge_q;
				bar_open      <= PRICE_W'(acc_open_q);
				bar_high      <= PRICE_W'(acc_high_q);
				bar_low       <= PRICE_W'(acc_low_q);
				bar_close     <= PRICE_W'(acc_close_q);
				bar_volume    <= acc_vol_q;
				is_empty_bar  <= 1'b0;
				gap_truncated <= 1'b0;
				i_q           <= GW'(1);
			end else begin
				bar_time_us   <= fe_q[TIME_W-1:0];
				bar_open      <= PRICE_W'(acc_close_q);
				bar_high      <= PRICE_W'(acc_close_q);
				bar_low       <= PRICE_W'(acc_close_q);
				bar_close     <= PRICE_W'(acc_close_q);
				bar_volume    <= '0;
				is_empty_bar  <= 1'b1;
				gap_truncated <= gap_cap && nxt_more;
				fe_q          <= fe_nxt;
				i_q           <= i_q + 1'b1;
			end
		end
	end

	a_trunc_on_last_filler: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && gap_truncated) |-> (is_empty_bar && last_of_run))
		else $error("truncated gap flagged on a bar that is not the last filler");

	a_gap_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_GAP) |-> ((i_q != '0) && (i_q <= GW'(MAX_GAP_BARS))))
		else $error("filler count out of range");

	a_filler_before_row: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == B_GAP) |-> fe_more)
		else $error("filler bar edge not below the new row time");

endmodule

>>> design/ohlcv_bar_resampler.sv
// ----------------------------------------------------------------------------
// ohlcv_bar_resampler
// Resamples time-ordered OHLCV rows into bars on a selectable period grid.
// ----------------------------------------------------------------------------
// A row that falls inside the open bar is taken as a merge. A row that opens
// a bar (the first row, or a row past the current edge) holds the input while
// the new edge is aligned to the period grid by a reciprocal multiply on the
// top 32 bits of the time, a multiply back to a remainder and at most two
// compare and subtract steps; either row also waits while the command queue
// is full. Bars leave from an output register at one beat per cycle while
// out_stall is low: a closing row yields the finished bar and then up to
// MAX_GAP_BARS filler bars, and a two-entry command queue lets the next
// row be classified while those beats drain. The user writes period_select
// through cfg_wr_en and cfg_wr_data only while idle; it is not enforced.
module ohlcv_bar_resampler #(
	parameter int MAX_GAP_BARS = obr_pkg::DEF_MAX_GAP_BARS,
	parameter int PRICE_BITS   = obr_pkg::DEF_PRICE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [obr_pkg::SEL_W-1:0]    cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [obr_pkg::TIME_W-1:0]   tick_time_us,
	input  logic [obr_pkg::PRICE_W-1:0]  row_open,
	input  logic [obr_pkg::PRICE_W-1:0]  row_high,
	input  logic [obr_pkg::PRICE_W-1:0]  row_low,
	input  logic [obr_pkg::PRICE_W-1:0]  row_close,
	input  logic [obr_pkg::VOL_IN_W-1:0] row_volume,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [obr_pkg::TIME_W-1:0]   bar_time_us,
	output logic [obr_pkg::PRICE_W-1:0]  bar_open,
	output logic [obr_pkg::PRICE_W-1:0]  bar_high,
	output logic [obr_pkg::PRICE_W-1:0]  bar_low,
	output logic [obr_pkg::PRICE_W-1:0]  bar_close,
	output logic [obr_pkg::VOL_W-1:0]    bar_volume,
	output logic                         is_empty_bar,
	output logic                         gap_truncated,
	output logic                         last_of_run
);
	import obr_pkg::*;

	logic [SEL_W-1:0] period_select_q;
	logic             push;
	cmd_t             push_cmd;
	logic             q_full;
	logic             pop;
	cmd_t             pop_cmd;
	logic             q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_select_q <= '0;
		end else if (cfg_wr_en) begin
			period_select_q <= cfg_wr_data;
		end
	end

	obr_front #(
		.PRICE_BITS(PRICE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.period_select(period_select_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.tick_time_us (tick_time_us),
		.row_open     (row_open),
		.row_high     (row_high),
		.row_low      (row_low),
		.row_close    (row_close),
		.row_volume   (row_volume),
		.push         (push),
		.push_cmd     (push_cmd),
		.q_full       (q_full)
	);

	obr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.empty   (q_empty)
	);

	obr_back #(
		.MAX_GAP_BARS(MAX_GAP_BARS),
		.PRICE_BITS  (PRICE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (pop_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bar_time_us  (bar_time_us),
		.bar_open     (bar_open),
		.bar_high     (bar_high),
		.bar_low      (bar_low),
		.bar_close    (bar_close),
		.bar_volume   (bar_volume),
		.is_empty_bar (is_empty_bar),
		.gap_truncated(gap_truncated),
		.last_of_run  (last_of_run)
	);

endmodule
